// ----- hw/rtl/cfgv_pkg.sv -----
package cfgv_pkg;

	localparam logic [7:0]  MAGIC_BYTE       = 8'hBE;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_RESIDUE      = 16'h1D0F;
	localparam logic [15:0] CRC_POLY         = 16'h1021;
	localparam logic [15:0] REC_HEADER_BYTES = 16'd6;
	localparam logic [15:0] REGION_RESET     = 16'd16384;
	localparam logic [7:0]  VERSION_RESET    = 8'd0;

	// Configuration register indexes.
	localparam logic CFG_REGION_BYTES     = 1'b0;
	localparam logic CFG_EXPECTED_VERSION = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC     = 3'd1;
	localparam logic [2:0] ST_REC_TOO_SMALL = 3'd2;
	localparam logic [2:0] ST_REC_BEYOND    = 3'd3;
	localparam logic [2:0] ST_CRC_MISMATCH  = 3'd4;

	// Command kinds passed from the framing front to the CRC back.
	localparam logic [1:0] K_START = 2'd0;
	localparam logic [1:0] K_TAKE  = 2'd1;
	localparam logic [1:0] K_FINAL = 2'd2;
	localparam logic [1:0] K_ERROR = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [2:0]  status;
		logic        version_ok;
		logic [15:0] length;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/cfgv_in_if.sv -----
interface cfgv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ----- hw/rtl/cfgv_out_if.sv -----
interface cfgv_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        version_match;
	logic [15:0] image_bytes;

	modport source (output valid, output status, output version_match, output image_bytes,
		input ready);
	modport sink (input valid, input status, input version_match, input image_bytes,
		output ready);
endinterface

// ----- hw/rtl/cfgv_front.sv -----
module cfgv_front (
	input  logic             clk,
	input  logic             arst_n,
	cfgv_in_if.sink          img,
	input  logic [15:0]      region_bytes,
	input  logic [7:0]       expected_version,
	input  logic             queue_full,
	output logic             push,
	output cfgv_pkg::cmd_t   cmd
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_MAGIC   = 3'd1;
	localparam logic [2:0] PH_SIZE_LO = 3'd2;
	localparam logic [2:0] PH_SIZE_HI = 3'd3;
	localparam logic [2:0] PH_BODY    = 3'd4;
	localparam logic [2:0] PH_CRC0    = 3'd5;
	localparam logic [2:0] PH_CRC1    = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] offset_q, offset_d;
	logic [15:0] remaining_q, remaining_d;
	logic [7:0]  size_lo_q, size_lo_d;
	logic        version_ok_q, version_ok_d;
	logic        accept;
	logic [15:0] offset_inc;
	logic [15:0] rec_size;
	logic [15:0] rec_start;
	logic [16:0] rec_end;
	logic [15:0] remaining_dec;

	assign img.ready = !queue_full;
	assign accept    = img.valid && img.ready;

	assign offset_inc    = (offset_q == 16'hFFFF) ? offset_q : offset_q + 16'd1;
	assign rec_size      = {img.data_byte, size_lo_q};
	assign rec_start     = (offset_q == 16'd0) ? 16'd0 : offset_q - 16'd1;
	assign rec_end       = {1'b0, rec_start} + {1'b0, rec_size};
	assign remaining_dec = (remaining_q == 16'd0) ? remaining_q : remaining_q - 16'd1;

	always_comb begin
		phase_d      = phase_q;
		offset_d     = offset_q;
		remaining_d  = remaining_q;
		size_lo_d    = size_lo_q;
		version_ok_d = version_ok_q;
		push         = 1'b0;
		cmd.kind       = cfgv_pkg::K_TAKE;
		cmd.data       = img.data_byte;
		cmd.status     = cfgv_pkg::ST_OK;
		cmd.version_ok = version_ok_q;
		cmd.length     = 16'd0;

		if (accept) begin
			if (img.first_byte) begin
				push           = 1'b1;
				cmd.kind       = cfgv_pkg::K_START;
				version_ok_d   = (img.data_byte == expected_version);
				cmd.version_ok = version_ok_d;
				offset_d       = 16'd1;
				remaining_d    = 16'd0;
				size_lo_d      = 8'd0;
				phase_d        = PH_MAGIC;
			end else begin
				case (phase_q)
					PH_MAGIC: begin
						push = 1'b1;
						if (img.data_byte != cfgv_pkg::MAGIC_BYTE) begin
							cmd.kind   = cfgv_pkg::K_ERROR;
							cmd.status = cfgv_pkg::ST_BAD_MAGIC;
							phase_d    = PH_IDLE;
						end else begin
							offset_d = offset_inc;
							phase_d  = PH_SIZE_LO;
						end
					end
					PH_SIZE_LO: begin
						push      = 1'b1;
						size_lo_d = img.data_byte;
						offset_d  = offset_inc;
						phase_d   = PH_SIZE_HI;
					end
					PH_SIZE_HI: begin
						push     = 1'b1;
						offset_d = offset_inc;
						if (rec_size == 16'd0) begin
							// The footer: only the stored CRC is left.
							phase_d = PH_CRC0;
						end else if (rec_end >= {1'b0, region_bytes}) begin
							cmd.kind   = cfgv_pkg::K_ERROR;
							cmd.status = cfgv_pkg::ST_REC_BEYOND;
							phase_d    = PH_IDLE;
						end else if (rec_size < cfgv_pkg::REC_HEADER_BYTES) begin
							cmd.kind   = cfgv_pkg::K_ERROR;
							cmd.status = cfgv_pkg::ST_REC_TOO_SMALL;
							phase_d    = PH_IDLE;
						end else begin
							remaining_d = rec_size - 16'd2;
							phase_d     = PH_BODY;
						end
					end
					PH_BODY: begin
						push        = 1'b1;
						offset_d    = offset_inc;
						remaining_d = remaining_dec;
						if (remaining_dec == 16'd0) begin
							phase_d = PH_SIZE_LO;
						end
					end
					PH_CRC0: begin
						push     = 1'b1;
						offset_d = offset_inc;
						phase_d  = PH_CRC1;
					end
					PH_CRC1: begin
						push       = 1'b1;
						offset_d   = offset_inc;
						cmd.kind   = cfgv_pkg::K_FINAL;
						cmd.length = offset_inc;
						phase_d    = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			offset_q     <= 16'd0;
			remaining_q  <= 16'd0;
			size_lo_q    <= 8'd0;
			version_ok_q <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			offset_q     <= offset_d;
			remaining_q  <= remaining_d;
			size_lo_q    <= size_lo_d;
			version_ok_q <= version_ok_d;
		end
	end

endmodule

// ----- hw/rtl/cfgv_fifo.sv -----
module cfgv_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cfgv_pkg::cmd_t   push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output cfgv_pkg::cmd_t   head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	cfgv_pkg::cmd_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/cfgv_back.sv -----
module cfgv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cfgv_pkg::cmd_t   cmd,
	output logic             pop,
	cfgv_out_if.source       res
);

	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        version_q;
	logic [15:0] length_q;
	logic        emits;

	assign pop      = cmd_valid && (!out_valid_q || res.ready);
	assign crc_base = (cmd.kind == cfgv_pkg::K_START) ? cfgv_pkg::CRC_INIT : crc_q;
	assign crc_next = cfgv_pkg::crc_byte(crc_base, cmd.data);
	assign emits    = (cmd.kind == cfgv_pkg::K_FINAL) || (cmd.kind == cfgv_pkg::K_ERROR);

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.version_match = version_q;
	assign res.image_bytes   = length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= cfgv_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q <= crc_next;
			end
			if (pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			version_q <= cmd.version_ok;
			length_q  <= cmd.length;
			if (cmd.kind == cfgv_pkg::K_FINAL) begin
				status_q <= (crc_next == cfgv_pkg::CRC_RESIDUE) ? cfgv_pkg::ST_OK
					: cfgv_pkg::ST_CRC_MISMATCH;
			end else begin
				status_q <= cmd.status;
			end
		end
	end

endmodule

// ----- hw/rtl/config_image_validator.sv -----
// Channel   Dir  Payload                                    Transfer
// img       in   data_byte[7:0], first_byte                 valid && ready
// res       out  status[2:0], version_match, image_bytes    valid && ready
// cfg       in   cfg_index 0 region_bytes, 1 expected_version  cfg_we
//
// One byte is taken per cycle while the command queue between the framing
// front and the CRC back has room; a result leaves after its last byte has
// passed through the queue and then the back's output register.
// Reset (arst_n low) idles the framing state, empties the queue and drops
// any result not yet transferred. A stall on res fills the queue of
// QUEUE_DEPTH commands before img.ready falls.
module config_image_validator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_wdata,
	cfgv_in_if.sink       img,
	cfgv_out_if.source    res
);

	logic [15:0]      region_q;
	logic [7:0]       version_q;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_valid;
	cfgv_pkg::cmd_t   front_cmd;
	cfgv_pkg::cmd_t   head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q  <= cfgv_pkg::REGION_RESET;
			version_q <= cfgv_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cfgv_pkg::CFG_REGION_BYTES:     region_q  <= cfg_wdata;
				cfgv_pkg::CFG_EXPECTED_VERSION: version_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	cfgv_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.img              (img),
		.region_bytes     (region_q),
		.expected_version (version_q),
		.queue_full       (queue_full),
		.push             (push),
		.cmd              (front_cmd)
	);

	cfgv_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_valid),
		.head      (head_cmd)
	);

	cfgv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (head_cmd),
		.pop       (pop),
		.res       (res)
	);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status <= cfgv_pkg::ST_CRC_MISMATCH))
		else $error("result status out of range");

	a_fault_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == cfgv_pkg::ST_BAD_MAGIC
			|| res.status == cfgv_pkg::ST_REC_TOO_SMALL
			|| res.status == cfgv_pkg::ST_REC_BEYOND) |-> (res.image_bytes == 16'd0))
		else $error("framing fault reported with nonzero length");

	a_ok_min_length: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == cfgv_pkg::ST_OK) |-> (res.image_bytes >= 16'd6))
		else $error("accepted image shorter than its minimal framing");

endmodule
